/* hw/rtl/b58_pkg.sv */
// ----------------------------------------------------------------------------
// b58_pkg
// Shared constants and the alphabet lookup for the base-58 byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b58_pkg;

  localparam int unsigned MAX_BYTES = 32;

  localparam int unsigned DigitW = 6;
  localparam int unsigned CarryW = 9;
  localparam int unsigned SymW   = 7;
  localparam int unsigned Radix  = 58;

  localparam logic [SymW-1:0] SymOne = 7'h31;

  localparam logic [Radix*8-1:0] Alphabet =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum logic [2:0] {
    StIdle,
    StFold,
    StOnes,
    StTooLong,
    StDigits
  } b58_state_e;

  function automatic logic [SymW-1:0] b58_char(input logic [DigitW-1:0] idx);
    logic [DigitW-1:0] idx_m;
    idx_m = (idx >= DigitW'(Radix)) ? idx - DigitW'(Radix) : idx;
    return Alphabet[(Radix - 1 - int'(idx_m)) * 8 +: SymW];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/b58_in_if.sv */
// ----------------------------------------------------------------------------
// b58_in_if
// Input channel of the encoder: one message byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/b58_out_if.sv */
// ----------------------------------------------------------------------------
// b58_out_if
// Output channel of the encoder: one ASCII symbol per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       last_symbol;
  logic       too_long;

  modport source (output valid, output symbol, output last_symbol, output too_long,
                  input ready);
  modport sink   (input valid, input symbol, input last_symbol, input too_long,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/b58_digit_mac.sv */
// ----------------------------------------------------------------------------
// b58_digit_mac
// One base-58 digit step: value = digit * 256 + carry, split into the new
// digit (value mod 58) and the outgoing carry (value div 58).
// ----------------------------------------------------------------------------
`default_nettype none

module b58_digit_mac
  import b58_pkg::*;
(
  input  wire logic [DigitW-1:0] digit_i,
  input  wire logic [CarryW-1:0] carry_i,
  output logic      [DigitW-1:0] digit_o,
  output logic      [CarryW-1:0] carry_o
);

  // 256 = 4 * 58 + 24, so only 24 * digit + carry needs a true division.
  localparam int unsigned TW    = 11;
  localparam int unsigned PW    = 20;
  localparam int unsigned Shift = 15;
  localparam int unsigned Recip = 565;

  logic [TW-1:0]     rem_t;
  logic [PW-1:0]     prod;
  logic [4:0]        quo;
  logic [TW-1:0]     quo_x58;

  assign rem_t   = TW'(digit_i) * TW'(24) + TW'(carry_i);
  assign prod    = PW'(rem_t) * PW'(Recip);
  assign quo     = prod[Shift +: 5];
  assign quo_x58 = TW'(quo) * TW'(Radix);
  assign digit_o = DigitW'(rem_t - quo_x58);
  assign carry_o = CarryW'({digit_i, 2'b00}) + CarryW'(quo);

endmodule

`default_nettype wire

/* hw/rtl/base58_byte_encoder.sv */
// ----------------------------------------------------------------------------
// base58_byte_encoder
// Streaming base-58 encoder: bytes in, ASCII symbols out.
// ----------------------------------------------------------------------------
// The message arrives one byte per beat with the final byte marked. Leading
// zero bytes are only counted, and the input stays ready for the next byte.
// Every later byte is folded into the digit register (StoreDepth digits,
// StoreDepth = MaxBytes * 138 / 100 + 1, 45 by default), which rotates once
// through the single multiply-by-256 unit, one digit per cycle; meanwhile the
// input is not ready. After the final byte it emits one '1' per leading zero
// byte, then the significant digits, through any output stall, and only then
// takes the next message. A message over MaxBytes yields a single too_long beat.
`default_nettype none

module base58_byte_encoder
  import b58_pkg::*;
#(
  parameter int unsigned MaxBytes = b58_pkg::MAX_BYTES
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  b58_in_if.sink       byte_i,
  b58_out_if.source    sym_o
);

  localparam int unsigned StoreDepth = MaxBytes * 138 / 100 + 1;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned BcW        = $clog2(MaxBytes + 1);

  b58_state_e state_q, state_d;

  logic [DigitW-1:0] store_q [StoreDepth];
  logic [CarryW-1:0] carry_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   lz_q;
  logic [CntW-1:0]   n_q;
  logic [BcW-1:0]    bc_q;
  logic              seen_q;
  logic              ovf_q;
  logic              last_pend_q;
  logic              sig_q;

  logic              out_valid_q;
  logic [SymW-1:0]   out_sym_q;
  logic              out_last_q;
  logic              out_tl_q;

  logic [DigitW-1:0] mac_digit;
  logic [CarryW-1:0] mac_carry;

  logic              accept;
  logic              slot;
  logic              do_fold;
  logic              ovf_set;
  logic              fold_step;
  logic              drain_step;
  logic              emit;
  logic [SymW-1:0]   emit_sym;
  logic              emit_last;
  logic              emit_tl;
  logic              top_sig;
  logic              idx_end;

  b58_digit_mac u_mac (
    .digit_i (store_q[0]),
    .carry_i (carry_q),
    .digit_o (mac_digit),
    .carry_o (mac_carry)
  );

  assign byte_i.ready      = (state_q == StIdle);
  assign accept            = byte_i.valid && byte_i.ready;
  assign slot              = !out_valid_q || sym_o.ready;
  assign idx_end           = (idx_q == '0);
  assign top_sig           = sig_q || (store_q[StoreDepth-1] != '0);

  assign ovf_set = !ovf_q && (bc_q >= BcW'(MaxBytes));
  assign do_fold = !ovf_q && !ovf_set && (seen_q || (byte_i.data_byte != 8'd0));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (do_fold) begin
            state_d = StFold;
          end else if (byte_i.last_byte) begin
            state_d = (ovf_q || ovf_set) ? StTooLong : StOnes;
          end
        end
      end
      StFold: begin
        if (idx_end) begin
          state_d = last_pend_q ? StOnes : StIdle;
        end
      end
      StOnes: begin
        if (n_q == lz_q || n_q == CntW'(StoreDepth)) begin
          state_d = StDigits;
        end
      end
      StTooLong: begin
        if (slot) begin
          state_d = StDigits;
        end
      end
      StDigits: begin
        if (drain_step && idx_end) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    fold_step  = 1'b0;
    drain_step = 1'b0;
    emit       = 1'b0;
    emit_sym   = SymOne;
    emit_last  = 1'b0;
    emit_tl    = 1'b0;
    case (state_q)
      StFold: begin
        fold_step = 1'b1;
      end
      StOnes: begin
        if (n_q != lz_q && n_q != CntW'(StoreDepth)) begin
          emit      = slot;
          emit_last = (!seen_q && (n_q + 1'b1 == lz_q)) ||
                      (n_q == CntW'(StoreDepth - 1));
        end
      end
      StTooLong: begin
        emit      = slot;
        emit_sym  = '0;
        emit_last = 1'b1;
        emit_tl   = 1'b1;
      end
      StDigits: begin
        if (top_sig && n_q != CntW'(StoreDepth)) begin
          emit       = slot;
          drain_step = slot;
          emit_sym   = b58_char(store_q[StoreDepth-1]);
          emit_last  = idx_end || (n_q == CntW'(StoreDepth - 1));
        end else begin
          drain_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      carry_q     <= '0;
      idx_q       <= '0;
      lz_q        <= '0;
      n_q         <= '0;
      bc_q        <= '0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      last_pend_q <= 1'b0;
      sig_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (accept) begin
        last_pend_q <= byte_i.last_byte;
        idx_q       <= IdxW'(StoreDepth - 1);
        carry_q     <= CarryW'(byte_i.data_byte);
        if (ovf_set) begin
          ovf_q <= 1'b1;
        end else if (!ovf_q) begin
          bc_q <= bc_q + 1'b1;
          if (do_fold) begin
            seen_q <= 1'b1;
          end else begin
            lz_q <= lz_q + 1'b1;
          end
        end
      end

      if (fold_step) begin
        for (int i = 0; i < StoreDepth - 1; i++) begin
          store_q[i] <= store_q[i+1];
        end
        store_q[StoreDepth-1] <= mac_digit;
        carry_q               <= mac_carry;
        idx_q                 <= idx_q - 1'b1;
      end

      if (state_q == StOnes && state_d == StDigits) begin
        idx_q <= IdxW'(StoreDepth - 1);
        sig_q <= 1'b0;
      end

      if (state_q == StTooLong && slot) begin
        idx_q <= IdxW'(StoreDepth - 1);
        sig_q <= 1'b0;
        n_q   <= CntW'(StoreDepth);
      end else if (emit) begin
        n_q <= n_q + 1'b1;
      end

      if (drain_step) begin
        for (int i = StoreDepth - 1; i > 0; i--) begin
          store_q[i] <= store_q[i-1];
        end
        store_q[0] <= '0;
        sig_q      <= top_sig;
        idx_q      <= idx_q - 1'b1;
        if (idx_end) begin
          lz_q        <= '0;
          n_q         <= '0;
          bc_q        <= '0;
          seen_q      <= 1'b0;
          ovf_q       <= 1'b0;
          last_pend_q <= 1'b0;
          sig_q       <= 1'b0;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (sym_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sym_q  <= emit_sym;
      out_last_q <= emit_last;
      out_tl_q   <= emit_tl;
    end
  end

  assign sym_o.valid       = out_valid_q;
  assign sym_o.symbol      = out_sym_q;
  assign sym_o.last_symbol = out_last_q;
  assign sym_o.too_long    = out_tl_q;

endmodule

`default_nettype wire

/* hw/rtl/b58_checker.sv */
// ----------------------------------------------------------------------------
// b58_checker
// Port-level checks for the base-58 byte encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b58_checker
  import b58_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            in_last_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [SymW-1:0] symbol_i,
  input wire logic            last_symbol_i,
  input wire logic            too_long_i
);

  // A beat waiting on the sink keeps its content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(symbol_i) &&
                                    $stable(last_symbol_i) && $stable(too_long_i))
    else $error("stalled output beat changed");

  // An overlong message ends in one beat carrying no symbol.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && too_long_i |-> last_symbol_i && (symbol_i == '0))
    else $error("too_long beat malformed");

  // Ordinary beats carry a printable character of the alphabet range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !too_long_i |-> (symbol_i >= SymOne) && (symbol_i <= 7'h7a))
    else $error("symbol outside alphabet range");

  // The final byte of a message closes the input while results are produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input accepted straight after final byte");

endmodule

bind base58_byte_encoder b58_checker u_b58_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .in_last_i     (byte_i.last_byte),
  .out_valid_i   (sym_o.valid),
  .out_ready_i   (sym_o.ready),
  .symbol_i      (sym_o.symbol),
  .last_symbol_i (sym_o.last_symbol),
  .too_long_i    (sym_o.too_long)
);

`default_nettype wire

/* sim/base58_byte_encoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base58_byte_encoder_tb
// Self-checking bench for the streaming base-58 encoder.
// ----------------------------------------------------------------------------
// Messages are queued as byte beats and offered by a clocked driver. When a
// beat is taken, a behavioural encoder in the bench folds it into its own
// digit store and, on the final byte, queues the symbols that should follow.
// A clocked monitor compares every symbol beat with the oldest prediction.
// Short directed messages come first, then random messages of mixed length,
// including all-zero, full-length and over-length ones. Both sides stall at
// random in changing proportions, with one long output hold-off.
// ----------------------------------------------------------------------------
module base58_byte_encoder_tb;
  import b58_pkg::*;

  localparam int StoreDepth = MAX_BYTES * 138 / 100 + 1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } byte_beat_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last_symbol;
    logic            too_long;
  } sym_beat_t;

  typedef enum logic [1:0] {
    PhSendLight,
    PhSendHeavy,
    PhNoIdle
  } idle_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  b58_in_if  byte_if ();
  b58_out_if sym_if ();

  base58_byte_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .sym_o  (sym_if)
  );

  always #5 clk_i = ~clk_i;

  byte_beat_t  pend_q[$];
  sym_beat_t   sym_exp_q[$];
  byte_beat_t  cur_beat;
  idle_phase_e idle_phase;

  string       digit_chars = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  logic [DigitW-1:0] digits [StoreDepth];
  int          zero_run;
  bit          seen_nz;
  int          byte_cnt;
  bit          overflow;

  int n_in, n_out, n_msgs, n_long, n_planned, err_cnt;
  int hold_left;
  bit hold_done;

  function automatic void clear_encoder();
    for (int k = 0; k < StoreDepth; k++) digits[k] = '0;
    zero_run = 0;
    seen_nz  = 1'b0;
    byte_cnt = 0;
    overflow = 1'b0;
  endfunction

  // Folds one accepted byte into the digit store and, on the final byte,
  // queues the symbols that the encoder should emit.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int        carry;
    int        v;
    int        top;
    int        n;
    sym_beat_t s;
    if (!overflow) begin
      if (byte_cnt >= MAX_BYTES) begin
        overflow = 1'b1;
      end else begin
        byte_cnt++;
        if (!seen_nz && b == 8'h00) begin
          zero_run++;
        end else begin
          seen_nz = 1'b1;
          carry   = int'(b);
          for (int k = 0; k < StoreDepth; k++) begin
            v         = int'(digits[k]) * 256 + carry;
            digits[k] = DigitW'(v % Radix);
            carry     = v / Radix;
          end
        end
      end
    end
    if (!fin) return;
    n_msgs++;
    if (overflow) begin
      s = '{symbol: '0, last_symbol: 1'b1, too_long: 1'b1};
      sym_exp_q.push_back(s);
      n_long++;
    end else begin
      n = 0;
      for (int k = 0; k < zero_run && n < StoreDepth; k++) begin
        s = '{symbol: SymOne, last_symbol: 1'b0, too_long: 1'b0};
        sym_exp_q.push_back(s);
        n++;
      end
      top = StoreDepth - 1;
      while (top >= 0 && digits[top] == '0) top--;
      for (int k = top; k >= 0 && n < StoreDepth; k--) begin
        s = '{symbol: SymW'(digit_chars[int'(digits[k]) % Radix]), last_symbol: 1'b0,
              too_long: 1'b0};
        sym_exp_q.push_back(s);
        n++;
      end
      if (n > 0) sym_exp_q[sym_exp_q.size()-1].last_symbol = 1'b1;
    end
    clear_encoder();
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last, input logic drain);
    byte_beat_t bt;
    bt = '{data: data, last: last, drain: drain};
    pend_q.push_back(bt);
  endtask

  task automatic add_msg(input int len, input int nz, input bit drain, input bit ff_fill);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      if (i < nz) begin
        d = 8'h00;
      end else if (ff_fill) begin
        d = 8'hFF;
      end else begin
        case ($urandom_range(9))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom_range(255));
        endcase
      end
      push_byte(d, i == len - 1, drain && i == 0);
    end
    n_planned += (len > MAX_BYTES + 1) ? MAX_BYTES + 1 : len;
  endtask

  // Byte driver.
  always @(posedge clk_i or negedge rst_ni) begin
    logic offer;
    logic gap;
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= '0;
      byte_if.last_byte <= 1'b0;
      idle_phase        <= PhSendLight;
    end else begin
      offer = byte_if.valid;
      if (byte_if.valid && byte_if.ready) begin
        encode_byte(cur_beat.data, cur_beat.last);
        n_in++;
        offer = 1'b0;
      end
      if (!offer && pend_q.size() > 0) begin
        case (idle_phase)
          PhSendLight: gap = $urandom_range(99) < 19;
          PhSendHeavy: gap = $urandom_range(99) < 49;
          default:     gap = 1'b0;
        endcase
        if (!gap && !(pend_q[0].drain && sym_exp_q.size() != 0)) begin
          cur_beat = pend_q.pop_front();
          offer    = 1'b1;
        end
      end
      byte_if.valid     <= offer;
      byte_if.data_byte <= cur_beat.data;
      byte_if.last_byte <= cur_beat.last;
      idle_phase        <= (n_in < 110) ? PhSendLight :
                           (n_in < 220) ? PhSendHeavy : PhNoIdle;
    end
  end

  // Symbol monitor and output back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    sym_beat_t want;
    logic      stall;
    if (!rst_ni) begin
      sym_if.ready <= 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else begin
      if (sym_if.valid && sym_if.ready) begin
        n_out++;
        if (sym_exp_q.size() == 0) begin
          $error("unexpected beat: symbol %0h last_symbol %0b too_long %0b",
                 sym_if.symbol, sym_if.last_symbol, sym_if.too_long);
          err_cnt++;
        end else begin
          want = sym_exp_q.pop_front();
          if (sym_if.symbol !== want.symbol) begin
            $error("symbol: expected %0h, got %0h", want.symbol, sym_if.symbol);
            err_cnt++;
          end
          if (sym_if.last_symbol !== want.last_symbol) begin
            $error("last_symbol: expected %0b, got %0b", want.last_symbol,
                   sym_if.last_symbol);
            err_cnt++;
          end
          if (sym_if.too_long !== want.too_long) begin
            $error("too_long: expected %0b, got %0b", want.too_long, sym_if.too_long);
            err_cnt++;
          end
        end
      end
      if (!hold_done && n_out >= 100) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        case (idle_phase)
          PhSendLight: stall = $urandom_range(99) < 49;
          PhSendHeavy: stall = $urandom_range(99) < 19;
          default:     stall = 1'b0;
        endcase
      end
      sym_if.ready <= !stall;
    end
  end

  initial begin
    int r;
    int len;
    int nz;
    rst_ni            = 1'b0;
    clear_encoder();

    // Single bytes, an all-zero message, leading zeros and zeros at the end.
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h01, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(8'hFF, i == 3, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'h55, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b0);
    push_byte(8'h01, 1'b1, 1'b0);
    push_byte(8'h3A, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    n_planned = 21;

    // Full-length messages and one over the limit, then the random mix.
    add_msg(MAX_BYTES, 0, 1'b1, 1'b1);
    add_msg(MAX_BYTES, MAX_BYTES, 1'b0, 1'b0);
    add_msg(MAX_BYTES + 1 + $urandom_range(3), 0, 1'b0, 1'b0);
    while (n_planned < 330) begin
      r = $urandom_range(99);
      if (r < 60)      len = $urandom_range(6, 1);
      else if (r < 85) len = $urandom_range(MAX_BYTES - 1, 7);
      else if (r < 92) len = MAX_BYTES;
      else             len = MAX_BYTES + $urandom_range(4, 1);
      r = $urandom_range(99);
      if (r < 70)      nz = 0;
      else if (r < 90) nz = $urandom_range((len < 3) ? len : 3, 1);
      else             nz = len;
      add_msg(len, nz, $urandom_range(19) == 0, $urandom_range(29) == 0);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || byte_if.valid || sym_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (2 * StoreDepth + 20) @(posedge clk_i);

    if (sym_exp_q.size() != 0) begin
      $error("%0d predicted symbols never arrived", sym_exp_q.size());
      err_cnt++;
    end
    $display("Encoded %0d messages (%0d too long) from %0d byte beats.",
             n_msgs, n_long, n_in);
    $display("Compared %0d symbol beats with the predicted encoding.", n_out);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
